// File: hdl/gvc_pkg.sv
// ----------------------------------------------------------------------------
// Greedy vertex cover package
// Command codes, register addresses and field widths used by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package gvc_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    localparam logic [0:0] REG_VERTEX_TOTAL = 1'd0;
    localparam logic [0:0] REG_EDGE_TOTAL   = 1'd1;

    localparam int DEG_W = 8;
    localparam int EDGE_W = 11;
    localparam int CNT_W = 9;

endpackage

`default_nettype wire

// File: hdl/greedy_vertex_cover_step.sv
// ----------------------------------------------------------------------------
// Greedy vertex cover step engine
// Stores a graph as per-vertex adjacency chains and, one request at a time,
// selects the next vertex of a greedy maximum-degree vertex cover.
// ----------------------------------------------------------------------------
// Usage
//   Requests enter on valid/stall with command, vertex_a and vertex_b; each
//   request yields exactly one result on the output valid/stall channel.
//   The block holds one request at a time: stall stays high from acceptance
//   until its result has been taken.
//   A clear result follows a sweep of the vertex tables; a valid add edge
//   result follows reads of both end vertices and, unless the store is full,
//   writes of the two new links. A step scans the active vertices, walking the
//   adjacency chain of each one examined and of the chosen vertex, then looks
//   for a remaining active vertex (the first step marks vertices of nonzero
//   degree active beforehand); every table is a single-port memory, read one word a cycle.
//   After reset the block sweeps the vertex tables and accepts no request
//   meanwhile; configuration writes are taken as ever.
//   While the receiver stalls, the result is held and no request is taken.
//   vertex_total and edge_total are written over the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_vertex_cover_step #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_LINKS    = 2048
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  vertex_a,
    input  wire logic [7:0]  vertex_b,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       chosen_vertex,
    output logic             found,
    output logic             finished,
    output logic [8:0]       cover_size,
    output logic             store_full
);
    import gvc_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int LW = $clog2(MAX_LINKS + 1);
    localparam int AW = $clog2(MAX_LINKS);
    localparam int SW = VW + 1;
    localparam int SCW = LW + DEG_W;

    localparam logic [4:0] S_INIT  = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_ADD0  = 5'd2;
    localparam logic [4:0] S_ADD1  = 5'd3;
    localparam logic [4:0] S_ADD2  = 5'd4;
    localparam logic [4:0] S_ADD3  = 5'd5;
    localparam logic [4:0] S_ACT0  = 5'd6;
    localparam logic [4:0] S_ACT1  = 5'd7;
    localparam logic [4:0] S_SC0   = 5'd8;
    localparam logic [4:0] S_SC1   = 5'd9;
    localparam logic [4:0] S_WK0   = 5'd10;
    localparam logic [4:0] S_WK1   = 5'd11;
    localparam logic [4:0] S_WK2   = 5'd12;
    localparam logic [4:0] S_CMP   = 5'd13;
    localparam logic [4:0] S_UP0   = 5'd14;
    localparam logic [4:0] S_UP1   = 5'd15;
    localparam logic [4:0] S_UP2   = 5'd16;
    localparam logic [4:0] S_UP3   = 5'd17;
    localparam logic [4:0] S_FIN0  = 5'd18;
    localparam logic [4:0] S_FIN1  = 5'd19;
    localparam logic [4:0] S_OUT   = 5'd20;
    localparam logic [4:0] S_ADDB  = 5'd21;

    // Vertex tables and link store, each single-port with registered read.
    logic [DEG_W-1:0] deg_mem [MAX_VERTICES];
    logic             act_mem [MAX_VERTICES];
    logic [LW-1:0]    head_mem [MAX_VERTICES];
    logic [LW-1:0]    next_mem [MAX_LINKS];
    logic [VW-1:0]    node_mem [MAX_LINKS];

    logic [VW-1:0]    v_addr;
    logic             v_we;
    logic             v_we_deg, v_we_act, v_we_head;
    logic [DEG_W-1:0] v_wdeg;
    logic             v_wact;
    logic [LW-1:0]    v_whead;
    logic [DEG_W-1:0] v_rdeg;
    logic             v_ract;
    logic [LW-1:0]    v_rhead;
    logic [AW-1:0]    l_addr;
    logic             l_we;
    logic [LW-1:0]    l_wnext;
    logic [VW-1:0]    l_wnode;
    logic [LW-1:0]    l_rnext;
    logic [VW-1:0]    l_rnode;

    always_ff @(posedge clk)
    begin
        if (v_we && v_we_deg)
        begin
            deg_mem[v_addr] <= v_wdeg;
        end
        if (v_we && v_we_act)
        begin
            act_mem[v_addr] <= v_wact;
        end
        if (v_we && v_we_head)
        begin
            head_mem[v_addr] <= v_whead;
        end
        v_rdeg  <= deg_mem[v_addr];
        v_ract  <= act_mem[v_addr];
        v_rhead <= head_mem[v_addr];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            next_mem[l_addr] <= l_wnext;
            node_mem[l_addr] <= l_wnode;
        end
        l_rnext <= next_mem[l_addr];
        l_rnode <= node_mem[l_addr];
    end

    logic [8:0]  vtot_reg;
    logic [10:0] etot_reg;
    logic [4:0]  state_reg, state_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [7:0]  a_reg, a_next, b_reg, b_next;
    logic [LW-1:0] used_reg, used_next;
    logic [EDGE_W-1:0] cov_reg, cov_next;
    logic [CNT_W-1:0]  sel_reg, sel_next;
    logic started_reg, started_next;
    logic [LW-1:0] link_reg, link_next_v;
    logic [LW-1:0] guard_reg, guard_next;
    logic [SCW-1:0] ns_reg, ns_next;
    logic [LW-1:0] vd_reg, vd_next;
    logic [DEG_W-1:0] cdeg_reg, cdeg_next;
    logic have_reg, have_next;
    logic [VW-1:0] best_reg, best_next;
    logic [DEG_W-1:0] bdeg_reg, bdeg_next;
    logic [SCW-1:0] bns_reg, bns_next;
    logic [LW-1:0] bvd_reg, bvd_next;
    logic [DEG_W-1:0] adeg_reg, adeg_next;
    logic anyact_reg, anyact_next;
    logic [7:0] o_ch_reg, o_ch_next;
    logic o_fd_reg, o_fd_next, o_fin_reg, o_fin_next, o_full_reg, o_full_next;
    logic ovalid_reg, ovalid_next;

    logic [SW-1:0] lim;
    logic [LW:0] used_p2;
    logic [EDGE_W:0] cov_sum;

    assign lim = (vtot_reg > MAX_VERTICES) ? SW'(MAX_VERTICES) : SW'(vtot_reg);
    assign used_p2 = {1'b0, used_reg} + (LW+1)'(2);
    assign cov_sum = {1'b0, cov_reg} + (EDGE_W+1)'(bdeg_reg);

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtot_reg <= 9'd1;
            etot_reg <= 11'd0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_VERTEX_TOTAL)
            begin
                vtot_reg <= pwdata[8:0];
            end
            else
            begin
                etot_reg <= pwdata[10:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_VERTEX_TOTAL) ? {23'd0, vtot_reg} : {21'd0, etot_reg};

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        cmd_next = cmd_reg;
        a_next = a_reg;
        b_next = b_reg;
        used_next = used_reg;
        cov_next = cov_reg;
        sel_next = sel_reg;
        started_next = started_reg;
        link_next_v = link_reg;
        guard_next = guard_reg;
        ns_next = ns_reg;
        vd_next = vd_reg;
        cdeg_next = cdeg_reg;
        have_next = have_reg;
        best_next = best_reg;
        bdeg_next = bdeg_reg;
        bns_next = bns_reg;
        bvd_next = bvd_reg;
        adeg_next = adeg_reg;
        anyact_next = anyact_reg;
        o_ch_next = o_ch_reg;
        o_fd_next = o_fd_reg;
        o_fin_next = o_fin_reg;
        o_full_next = o_full_reg;
        ovalid_next = ovalid_reg;
        v_addr = idx_reg[VW-1:0];
        v_we = 1'b0;
        v_we_deg = 1'b0;
        v_we_act = 1'b0;
        v_we_head = 1'b0;
        v_wdeg = '0;
        v_wact = 1'b0;
        v_whead = LW'(MAX_LINKS);
        l_addr = link_reg[AW-1:0];
        l_we = 1'b0;
        l_wnext = '0;
        l_wnode = '0;
        unique case (state_reg)
            S_INIT:
            begin
                v_we = 1'b1;
                v_we_deg = 1'b1;
                v_we_act = 1'b1;
                v_we_head = 1'b1;
                if (idx_reg == SW'(MAX_VERTICES - 1))
                begin
                    state_next = (cmd_reg == CMD_CLEAR && ovalid_reg) ? S_OUT : S_IDLE;
                end
                idx_next = idx_reg + SW'(1);
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = command;
                    a_next = vertex_a;
                    b_next = vertex_b;
                    o_ch_next = '0;
                    o_fd_next = 1'b0;
                    o_fin_next = 1'b0;
                    o_full_next = 1'b0;
                    idx_next = '0;
                    case (command)
                        CMD_CLEAR:
                        begin
                            used_next = '0;
                            cov_next = '0;
                            sel_next = '0;
                            started_next = 1'b0;
                            ovalid_next = 1'b1;
                            state_next = S_INIT;
                        end
                        CMD_ADD:
                        begin
                            if (vertex_a != vertex_b && 32'(vertex_a) < MAX_VERTICES
                                && 32'(vertex_b) < MAX_VERTICES)
                            begin
                                state_next = S_ADD0;
                            end
                            else
                            begin
                                state_next = S_OUT;
                            end
                        end
                        CMD_STEP:
                        begin
                            state_next = started_reg ? S_SC0 : S_ACT0;
                            have_next = 1'b0;
                            anyact_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_ADD0:
            begin
                v_addr = a_reg[VW-1:0];
                state_next = S_ADDB;
            end
            S_ADDB:
            begin
                v_addr = b_reg[VW-1:0];
                adeg_next = v_rdeg;
                link_next_v = v_rhead;
                state_next = S_ADD1;
            end
            S_ADD1:
            begin
                if (used_p2 > (LW+1)'(MAX_LINKS) || adeg_reg == 8'hFF || v_rdeg == 8'hFF)
                begin
                    o_full_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    v_addr = b_reg[VW-1:0];
                    v_we = 1'b1;
                    v_we_deg = 1'b1;
                    v_we_head = 1'b1;
                    v_wdeg = v_rdeg + 8'd1;
                    v_whead = used_reg + LW'(1);
                    l_addr = AW'(used_reg + LW'(1));
                    l_we = 1'b1;
                    l_wnext = v_rhead;
                    l_wnode = a_reg[VW-1:0];
                    state_next = S_ADD2;
                end
            end
            S_ADD2:
            begin
                v_addr = a_reg[VW-1:0];
                v_we = 1'b1;
                v_we_deg = 1'b1;
                v_we_head = 1'b1;
                v_wdeg = adeg_reg + 8'd1;
                v_whead = used_reg;
                l_addr = used_reg[AW-1:0];
                l_we = 1'b1;
                l_wnext = link_reg;
                l_wnode = b_reg[VW-1:0];
                used_next = used_reg + LW'(2);
                state_next = S_OUT;
            end
            S_ACT0:
            begin
                if (idx_reg >= lim)
                begin
                    started_next = 1'b1;
                    idx_next = '0;
                    state_next = S_SC0;
                end
                else
                begin
                    state_next = S_ACT1;
                end
            end
            S_ACT1:
            begin
                if (v_rdeg != '0)
                begin
                    v_we = 1'b1;
                    v_we_act = 1'b1;
                    v_wact = 1'b1;
                end
                idx_next = idx_reg + SW'(1);
                state_next = S_ACT0;
            end
            S_SC0:
            begin
                if (cov_reg >= etot_reg)
                begin
                    o_fin_next = 1'b1;
                    state_next = S_OUT;
                end
                else if (idx_reg >= lim)
                begin
                    if (have_reg)
                    begin
                        state_next = S_UP0;
                    end
                    else
                    begin
                        o_fin_next = 1'b1;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    state_next = S_SC1;
                end
            end
            S_SC1:
            begin
                cdeg_next = v_rdeg;
                ns_next = '0;
                vd_next = '0;
                guard_next = '0;
                link_next_v = v_rhead;
                if (!v_ract || (have_reg && v_rdeg < bdeg_reg))
                begin
                    idx_next = idx_reg + SW'(1);
                    state_next = S_SC0;
                end
                else
                begin
                    state_next = S_WK0;
                end
            end
            S_WK0:
            begin
                if (link_reg >= used_reg || guard_reg == LW'(MAX_LINKS))
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_WK1;
                end
            end
            S_WK1:
            begin
                v_addr = l_rnode;
                link_next_v = l_rnext;
                guard_next = guard_reg + LW'(1);
                state_next = S_WK2;
            end
            S_WK2:
            begin
                if (v_ract)
                begin
                    ns_next = ns_reg + SCW'(v_rdeg);
                    if (v_rdeg == 8'd1)
                    begin
                        vd_next = vd_reg + LW'(1);
                    end
                end
                state_next = S_WK0;
            end
            S_CMP:
            begin
                if (!have_reg || cdeg_reg > bdeg_reg || ns_reg < bns_reg
                    || (ns_reg == bns_reg && vd_reg > bvd_reg))
                begin
                    have_next = 1'b1;
                    best_next = idx_reg[VW-1:0];
                    bdeg_next = cdeg_reg;
                    bns_next = ns_reg;
                    bvd_next = vd_reg;
                end
                idx_next = idx_reg + SW'(1);
                state_next = S_SC0;
            end
            S_UP0:
            begin
                v_addr = best_reg;
                cov_next = cov_sum > (EDGE_W+1)'(2047) ? 11'd2047 : cov_sum[EDGE_W-1:0];
                guard_next = '0;
                state_next = S_UP1;
            end
            S_UP1:
            begin
                if (guard_reg == '0)
                begin
                    link_next_v = v_rhead;
                    guard_next = LW'(1);
                end
                else if (link_reg >= used_reg || guard_reg == LW'(MAX_LINKS + 1))
                begin
                    v_addr = best_reg;
                    v_we = 1'b1;
                    v_we_act = 1'b1;
                    v_wact = 1'b0;
                    idx_next = '0;
                    state_next = S_FIN0;
                    if (sel_reg != 9'h1FF)
                    begin
                        sel_next = sel_reg + 9'd1;
                    end
                end
                else
                begin
                    state_next = S_UP2;
                end
            end
            S_UP2:
            begin
                v_addr = l_rnode;
                link_next_v = l_rnext;
                b_next = 8'(l_rnode);
                guard_next = guard_reg + LW'(1);
                state_next = S_UP3;
            end
            S_UP3:
            begin
                v_addr = b_reg[VW-1:0];
                if (v_ract && v_rdeg != '0)
                begin
                    v_we = 1'b1;
                    v_we_deg = 1'b1;
                    v_wdeg = v_rdeg - 8'd1;
                    if (v_rdeg == 8'd1)
                    begin
                        v_we_act = 1'b1;
                        v_wact = 1'b0;
                    end
                end
                state_next = S_UP1;
            end
            S_FIN0:
            begin
                if (idx_reg >= lim || anyact_reg)
                begin
                    o_ch_next = 8'(best_reg);
                    o_fd_next = 1'b1;
                    o_fin_next = (cov_reg >= etot_reg) || !anyact_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_FIN1;
                end
            end
            S_FIN1:
            begin
                anyact_next = v_ract;
                idx_next = idx_reg + SW'(1);
                state_next = S_FIN0;
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                if (ovalid_reg && !out_stall)
                begin
                    ovalid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            idx_reg <= '0;
            cmd_reg <= CMD_ADD;
            used_reg <= '0;
            cov_reg <= '0;
            sel_reg <= '0;
            started_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            have_reg <= 1'b0;
            anyact_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            cmd_reg <= cmd_next;
            used_reg <= used_next;
            cov_reg <= cov_next;
            sel_reg <= sel_next;
            started_reg <= started_next;
            ovalid_reg <= ovalid_next;
            have_reg <= have_next;
            anyact_reg <= anyact_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        link_reg <= link_next_v;
        guard_reg <= guard_next;
        ns_reg <= ns_next;
        vd_reg <= vd_next;
        cdeg_reg <= cdeg_next;
        best_reg <= best_next;
        bdeg_reg <= bdeg_next;
        bns_reg <= bns_next;
        bvd_reg <= bvd_next;
        adeg_reg <= adeg_next;
        o_ch_reg <= o_ch_next;
        o_fd_reg <= o_fd_next;
        o_fin_reg <= o_fin_next;
        o_full_reg <= o_full_next;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg && (state_reg == S_OUT);
    assign chosen_vertex = o_ch_reg;
    assign found = o_fd_reg;
    assign finished = o_fin_reg;
    assign cover_size = sel_reg;
    assign store_full = o_full_reg;

endmodule

`default_nettype wire
